/* hdl/lwct_pkg.sv */
// shared types, constants and helper functions of the lattice walk cover tracker
// no dependencies; imported by every module of the block but lwct_ram
package lwct_pkg;

	localparam int MAX_DIMS   = 3;
	localparam int SIDE_MAX   = 16;
	localparam int COORD_BITS = 16;
	localparam int SIDE_W     = 5;
	localparam int DIM_W      = 2;
	localparam int AXIS_W     = 2;
	localparam int AGE_W      = 32;
	localparam int DIST_W     = 32;
	localparam int COUNT_W    = 13;
	localparam int SITE_BITS  = $clog2(SIDE_MAX);
	localparam int MAP_DEPTH  = SIDE_MAX ** MAX_DIMS;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_2    = 3'd4;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		OP_PLACE,
		OP_STEP,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [AXIS_W-1:0]      axis;
		logic                   sign;
		coord_t [MAX_DIMS-1:0]  start;
	} qentry_t;

	typedef struct packed {
		logic [DIM_W-1:0]                dim;
		logic                            wrap;
		logic [MAX_DIMS-1:0][SIDE_W-1:0] side;
	} cfg_t;

	typedef struct packed {
		coord_t [MAX_DIMS-1:0] coord;
		logic [AGE_W-1:0]      age;
		logic [DIST_W-1:0]     max_dist_sq;
		logic                  alive;
		logic                  new_site;
		logic [COUNT_W-1:0]    visited_count;
		logic                  covered;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOVE,
		ST_REM,
		ST_SQ,
		ST_SQ_ADD,
		ST_MAP_RD,
		ST_MAP_CHK,
		ST_EMIT
	} back_state_t;

	// a dimension count of zero acts as one
	function automatic logic [DIM_W-1:0] dims_used(input logic [DIM_W-1:0] d);
		return (d == '0) ? DIM_W'(1) : d;
	endfunction

	// sides are held to 1..SIDE_MAX
	function automatic logic [SIDE_W-1:0] side_eff(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s == '0) r = SIDE_W'(1);
		else if (s > SIDE_W'(SIDE_MAX)) r = SIDE_W'(SIDE_MAX);
		return r;
	endfunction

endpackage

/* hdl/lattice_walk_cover_tracker.sv */
// top level of the lattice walk cover tracker: configuration registers, front end, back end
// depends on lwct_pkg, lwct_front, lwct_back (and through it lwct_ram, lwct_rem)

// One walker on a 1 to 3 dimensional lattice, either a free lattice with saturating
// coordinates or a periodic torus (sides 1..16) with a 4096 entry visited map. Each input
// transaction produces exactly one result transaction. Transactions enter a two entry
// queue, so the input side keeps taking transactions while a result waits on the output.
// The back end sequencer sets the rate: a step in periodic mode adds a map read, then a
// check and mark, and a coordinate left outside the torus by a register change must
// first be reduced by the bit-serial remainder unit. A place is followed by a sweep that
// rewrites all 4096 entries of the visited map, one entry per cycle, during which no
// transaction is taken from the queue. The same sweep runs once after reset. Configuration
// registers are written through the plain write port; the user must write them only while
// the block is idle, which the block itself does not enforce.
module lattice_walk_cover_tracker
	import lwct_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [SIDE_W-1:0]         cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [AXIS_W-1:0]         axis,
	input  logic                      sign,
	input  logic signed [COORD_BITS-1:0] start_0,
	input  logic signed [COORD_BITS-1:0] start_1,
	input  logic signed [COORD_BITS-1:0] start_2,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_BITS-1:0] coord_0,
	output logic signed [COORD_BITS-1:0] coord_1,
	output logic signed [COORD_BITS-1:0] coord_2,
	output logic [AGE_W-1:0]          age,
	output logic [DIST_W-1:0]         max_dist_sq,
	output logic                      alive,
	output logic                      new_site,
	output logic [COUNT_W-1:0]        visited_count,
	output logic                      covered
);

	cfg_t    cfg_q;
	logic    q_valid;
	qentry_t q_entry;
	logic    q_pop;
	res_t    res;

	// configuration registers, unlisted indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim  <= DIM_W'(2);
			cfg_q.wrap <= 1'b1;
			cfg_q.side <= {MAX_DIMS{SIDE_W'(16)}};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DIM_COUNT: cfg_q.dim     <= cfg_data[DIM_W-1:0];
				REG_WRAP_MODE: cfg_q.wrap    <= cfg_data[0];
				REG_SIDE_0:    cfg_q.side[0] <= cfg_data;
				REG_SIDE_1:    cfg_q.side[1] <= cfg_data;
				REG_SIDE_2:    cfg_q.side[2] <= cfg_data;
				default:       ;
			endcase
		end
	end

	// front end classifies each transaction, clamps its start in periodic mode, and queues it
	lwct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.axis     (axis),
		.sign     (sign),
		.start    ({start_2, start_1, start_0}),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	// back end carries out moves, distances and map updates
	lwct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign coord_0       = res.coord[0];
	assign coord_1       = res.coord[1];
	assign coord_2       = res.coord[2];
	assign age           = res.age;
	assign max_dist_sq   = res.max_dist_sq;
	assign alive         = res.alive;
	assign new_site      = res.new_site;
	assign visited_count = res.visited_count;
	assign covered       = res.covered;

	// full cover implies at least one visited site
	a_cover_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && covered) |-> (visited_count != '0))
		else $error("cover reported with empty visited count");

	// a first visit is always counted
	a_new_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_site) |-> (visited_count != '0))
		else $error("new site reported with empty visited count");

	// a first visit with zero age comes only from a placement, which counts one site
	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_site && age == '0) |-> (visited_count == COUNT_W'(1)))
		else $error("placement reported wrong visited count");

endmodule

/* hdl/lwct_ram.sv */
// generic simple dual port ram with registered read
// no dependencies
module lwct_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

/* hdl/lwct_rem.sv */
// iterative remainder unit, one quotient bit per cycle
// depends on lwct_pkg
module lwct_rem
	import lwct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS:0]   dividend,
	input  logic [SIDE_W-1:0]     divisor,
	output logic                  done,
	output logic [SIDE_W-1:0]     rem
);

	localparam int STEPS = COORD_BITS + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [COORD_BITS:0] dd_q;
	logic [SIDE_W-1:0]   rem_q;
	logic [SIDE_W-1:0]   div_q;
	logic [SIDE_W:0]     trial;

	assign trial = {rem_q, dd_q[COORD_BITS]};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dd_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dd_q <= {dd_q[COORD_BITS-1:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= SIDE_W'(trial - {1'b0, div_q});
			else rem_q <= trial[SIDE_W-1:0];
		end
	end

endmodule

/* hdl/lwct_front.sv */
// front end: takes input transactions, classifies and clamps them, two entry queue
// depends on lwct_pkg
module lwct_front
	import lwct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [AXIS_W-1:0]     axis,
	input  logic                  sign,
	input  coord_t [MAX_DIMS-1:0] start,
	output logic                  q_valid,
	output qentry_t               q_entry,
	input  logic                  q_pop
);

	qentry_t          ent;
	qentry_t          mem_q [2];
	logic [1:0]       cnt_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic             push;
	logic [DIM_W-1:0] d;
	logic [SIDE_W-1:0] s_m1;

	assign d = dims_used(cfg.dim);

	always_comb begin
		ent      = '0;
		ent.axis = axis;
		ent.sign = sign;
		s_m1     = '0;
		if (!cmd) ent.kind = OP_PLACE;
		else if ({1'b0, axis} < {1'b0, d}) ent.kind = OP_STEP;
		else ent.kind = OP_NOP;
		for (int a = 0; a < MAX_DIMS; a++) begin
			ent.start[a] = '0;
			if (a < int'(d)) begin
				ent.start[a] = start[a];
				if (cfg.wrap) begin
					s_m1 = side_eff(cfg.side[a]) - SIDE_W'(1);
					if (start[a] < 0) ent.start[a] = '0;
					else if ($unsigned(start[a]) > {{(COORD_BITS-SIDE_W){1'b0}}, s_m1})
						ent.start[a] = {{(COORD_BITS-SIDE_W){1'b0}}, s_m1};
				end
			end
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (q_pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= ent;
	end

endmodule

/* hdl/lwct_back.sv */
// back end: sequencer that moves the walker, sums squares, updates the visited map
// depends on lwct_pkg, lwct_ram and lwct_rem
module lwct_back
	import lwct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  qentry_t q_entry,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_stall,
	output res_t    res
);

	back_state_t            state_q, state_d;
	op_kind_t               op_q;
	logic [AXIS_W-1:0]      axis_q;
	logic                   sign_q;
	coord_t [MAX_DIMS-1:0]  pos_q;
	logic [AGE_W-1:0]       age_q;
	logic [DIST_W-1:0]      max_q;
	logic [DIST_W+1:0]      acc_q;
	logic [DIST_W-1:0]      prod_q;
	logic [1:0]             sq_cnt_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   fresh_q;
	logic [MAP_AW-1:0]      clr_cnt_q;
	logic [MAP_AW-1:0]      clr_idx_q;
	logic                   clr_mark_q;
	logic                   out_valid_q;
	res_t                   res_q;
	logic [2*SIDE_W-1:0]    tsz_a_q;
	logic [COUNT_W-1:0]     tsz_q;

	logic [DIM_W-1:0]       d;
	logic                   periodic;
	coord_t                 cur;
	logic signed [COORD_BITS:0] v;
	logic [SIDE_W-1:0]      s;
	logic                   fast;
	coord_t                 fast_val;
	coord_t                 new_val;
	logic [COORD_BITS:0]    v_mag;
	logic                   rem_start, rem_done;
	logic [SIDE_W-1:0]      rem_val;
	logic                   move_done;
	logic [MAP_AW-1:0]      site_idx;
	logic                   site_ok;
	coord_t                 sq_pos;
	logic [COORD_BITS:0]    sq_neg;
	logic [COORD_BITS-1:0]  sq_mag;
	logic [DIST_W-1:0]      sq_val;
	logic [DIST_W+1:0]      acc_fin;
	logic [DIST_W-1:0]      dist_sat;
	logic                   ram_we, ram_re, ram_wdata, ram_rdata;
	logic [MAP_AW-1:0]      ram_waddr;
	logic                   out_load;

	assign d        = dims_used(cfg.dim);
	assign periodic = cfg.wrap;

	// moving coordinate
	always_comb begin
		unique case (axis_q)
			2'd1:    begin cur = pos_q[1]; s = side_eff(cfg.side[1]); end
			2'd2:    begin cur = pos_q[2]; s = side_eff(cfg.side[2]); end
			default: begin cur = pos_q[0]; s = side_eff(cfg.side[0]); end
		endcase
		v        = {cur[COORD_BITS-1], cur} + (sign_q ? -17'sd1 : 17'sd1);
		v_mag    = v[COORD_BITS] ? (COORD_BITS+1)'(-v) : v;
		fast     = 1'b1;
		fast_val = '0;
		if (!periodic) begin
			if (v > (COORD_BITS+1)'(32767)) fast_val = coord_t'(16'sh7fff);
			else if (v < -(COORD_BITS+1)'(32768)) fast_val = coord_t'(16'sh8000);
			else fast_val = v[COORD_BITS-1:0];
		end else if (v == -17'sd1) begin
			fast_val = {{(COORD_BITS-SIDE_W){1'b0}}, SIDE_W'(s - SIDE_W'(1))};
		end else if (!v[COORD_BITS] && v < {{(COORD_BITS+1-SIDE_W){1'b0}}, s}) begin
			fast_val = v[COORD_BITS-1:0];
		end else if (v == {{(COORD_BITS+1-SIDE_W){1'b0}}, s}) begin
			fast_val = '0;
		end else begin
			fast = 1'b0;
		end
		if (state_q == ST_REM) begin
			if (v[COORD_BITS] && rem_val != '0)
				new_val = {{(COORD_BITS-SIDE_W){1'b0}}, SIDE_W'(s - rem_val)};
			else
				new_val = {{(COORD_BITS-SIDE_W){1'b0}}, rem_val};
		end else begin
			new_val = fast_val;
		end
	end

	lwct_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (v_mag),
		.divisor  (s),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// map address of the current site and whether it lies inside the torus
	always_comb begin
		site_idx = '0;
		site_ok  = 1'b1;
		for (int a = 0; a < MAX_DIMS; a++) begin
			if (a < int'(d)) begin
				if (pos_q[a] < 0 ||
				    $unsigned(pos_q[a]) >= {{(COORD_BITS-SIDE_W){1'b0}}, side_eff(cfg.side[a])})
					site_ok = 1'b0;
				site_idx[a*SITE_BITS +: SITE_BITS] = pos_q[a][SITE_BITS-1:0];
			end
		end
	end

	// square of one axis
	always_comb begin
		unique case (sq_cnt_q)
			2'd1:    sq_pos = pos_q[1];
			2'd2:    sq_pos = pos_q[2];
			default: sq_pos = pos_q[0];
		endcase
		sq_neg = -{sq_pos[COORD_BITS-1], sq_pos};
		sq_mag = sq_pos[COORD_BITS-1] ? sq_neg[COORD_BITS-1:0] : sq_pos;
		sq_val = ({1'b0, sq_cnt_q} < {1'b0, d}) ?
			DIST_W'({{(DIST_W-COORD_BITS){1'b0}}, sq_mag} *
			        {{(DIST_W-COORD_BITS){1'b0}}, sq_mag}) : '0;
		acc_fin  = acc_q + {2'b00, prod_q};
		dist_sat = (acc_fin[DIST_W+1:DIST_W] != 2'b00) ? '1 : acc_fin[DIST_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_cnt_q == '1) state_d = ST_IDLE;
			ST_IDLE:    if (q_valid) state_d = (q_entry.kind == OP_STEP) ? ST_MOVE : ST_SQ;
			ST_MOVE:    state_d = rem_start ? ST_REM : ST_SQ;
			ST_REM:     if (rem_done) state_d = ST_SQ;
			ST_SQ:      if (sq_cnt_q == 2'd2) state_d = ST_SQ_ADD;
			ST_SQ_ADD:  state_d = (op_q == OP_STEP && periodic && site_ok) ? ST_MAP_RD : ST_EMIT;
			ST_MAP_RD:  state_d = ST_MAP_CHK;
			ST_MAP_CHK: state_d = ST_EMIT;
			ST_EMIT:    if (out_load) state_d = (op_q == OP_PLACE) ? ST_CLEAR : ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid;
		rem_start = (state_q == ST_MOVE) && periodic && !fast;
		move_done = ((state_q == ST_MOVE) && !rem_start) || ((state_q == ST_REM) && rem_done);
		ram_re    = (state_q == ST_MAP_RD);
		ram_we    = 1'b0;
		ram_waddr = site_idx;
		ram_wdata = 1'b1;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = clr_mark_q && (clr_cnt_q == clr_idx_q);
		end else if (state_q == ST_MAP_CHK) begin
			ram_we = !ram_rdata;
		end
		out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	end

	lwct_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (site_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_mark_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			age_q       <= '0;
			max_q       <= '0;
			count_q     <= '0;
			op_q        <= OP_NOP;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
			if (q_pop) begin
				op_q <= q_entry.kind;
				if (q_entry.kind == OP_PLACE) begin
					pos_q   <= q_entry.start;
					age_q   <= '0;
					count_q <= '0;
				end
			end
			if (move_done) begin
				unique case (axis_q)
					2'd1:    pos_q[1] <= new_val;
					2'd2:    pos_q[2] <= new_val;
					default: pos_q[0] <= new_val;
				endcase
				if (age_q != '1) age_q <= age_q + AGE_W'(1);
			end
			if (state_q == ST_SQ_ADD) begin
				if (op_q == OP_PLACE) begin
					max_q <= dist_sat;
					if (periodic) count_q <= COUNT_W'(1);
				end else if (op_q == OP_STEP && dist_sat > max_q) begin
					max_q <= dist_sat;
				end
			end
			if (state_q == ST_MAP_CHK && !ram_rdata) count_q <= count_q + COUNT_W'(1);
			if (out_load) begin
				out_valid_q <= 1'b1;
				clr_cnt_q   <= '0;
				clr_mark_q  <= periodic && (op_q == OP_PLACE);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tsz_a_q <= {{SIDE_W{1'b0}}, side_eff(cfg.side[0])} *
		           {{SIDE_W{1'b0}}, (d >= DIM_W'(2)) ? side_eff(cfg.side[1]) : SIDE_W'(1)};
		tsz_q   <= COUNT_W'({{(COUNT_W-2*SIDE_W){1'b0}}, tsz_a_q} *
		           {{(COUNT_W-SIDE_W){1'b0}},
		            (d >= DIM_W'(3)) ? side_eff(cfg.side[2]) : SIDE_W'(1)});
		if (q_pop) begin
			axis_q   <= q_entry.axis;
			sign_q   <= q_entry.sign;
			sq_cnt_q <= '0;
			acc_q    <= '0;
			prod_q   <= '0;
			fresh_q  <= 1'b0;
		end
		if (state_q == ST_SQ) begin
			prod_q   <= sq_val;
			acc_q    <= acc_fin;
			sq_cnt_q <= sq_cnt_q + 2'd1;
		end
		if (state_q == ST_SQ_ADD) begin
			acc_q <= acc_fin;
			if (op_q == OP_PLACE && periodic) fresh_q <= 1'b1;
		end
		if (state_q == ST_MAP_CHK && !ram_rdata) fresh_q <= 1'b1;
		if (out_load) begin
			clr_idx_q           <= site_idx;
			res_q.coord         <= pos_q;
			res_q.age           <= age_q;
			res_q.max_dist_sq   <= max_q;
			res_q.alive         <= (acc_q != '0);
			res_q.new_site      <= periodic && fresh_q;
			res_q.visited_count <= periodic ? count_q : '0;
			res_q.covered       <= periodic && (count_q >= tsz_q);
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* bench/tb_lattice_walk_cover_tracker.sv */
// self-checking testbench of lattice_walk_cover_tracker: directed and random walks
// depends on lwct_pkg and the block's RTL; a scoreboard class predicts every result

module tb_lattice_walk_cover_tracker;
	import lwct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1500000;
	// a place is followed by a sweep of the whole visited map
	localparam int SWEEP_WAIT   = MAP_DEPTH + 100;
	localparam bit CMD_PLACE    = 1'b0;
	localparam bit CMD_STEP     = 1'b1;

	// walker model and queue of expected results
	class walk_scoreboard;
		logic [DIM_W-1:0]  dim_reg;
		logic              wrap_reg;
		logic [SIDE_W-1:0] side_reg [MAX_DIMS];
		longint            pos [MAX_DIMS];
		bit [AGE_W-1:0]    age_cnt;
		bit [DIST_W-1:0]   far_sq;
		bit                seen [MAP_DEPTH];
		int                sites;
		res_t              pending [$];
		int                errors;
		int                n_places, n_steps, n_checked, n_covered;

		function new();
			dim_reg = 2'd2;
			wrap_reg = 1'b1;
			foreach (side_reg[a]) side_reg[a] = 5'd16;
			foreach (pos[a]) pos[a] = 0;
			age_cnt = '0;
			far_sq = '0;
			foreach (seen[i]) seen[i] = 1'b0;
			sites = 0;
			errors = 0;
			n_places = 0;
			n_steps = 0;
			n_checked = 0;
			n_covered = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
			case (idx)
				REG_DIM_COUNT: dim_reg = val[DIM_W-1:0];
				REG_WRAP_MODE: wrap_reg = val[0];
				REG_SIDE_0: side_reg[0] = val;
				REG_SIDE_1: side_reg[1] = val;
				REG_SIDE_2: side_reg[2] = val;
				default: ;
			endcase
		endfunction

		function int axes_in_use();
			return (dim_reg == 0) ? 1 : int'(dim_reg);
		endfunction

		function longint side_of(int a);
			longint s;
			s = side_reg[a];
			if (s < 1) s = 1;
			if (s > SIDE_MAX) s = SIDE_MAX;
			return s;
		endfunction

		function bit [DIST_W-1:0] radius_sq();
			longint sum;
			sum = 0;
			for (int a = 0; a < axes_in_use(); a++) sum += pos[a] * pos[a];
			return (sum > 64'hFFFF_FFFF) ? '1 : sum[DIST_W-1:0];
		endfunction

		// marks the current site, returns 1 on a first visit
		function bit visit_site();
			longint idx, scale;
			idx = 0;
			scale = 1;
			for (int a = 0; a < axes_in_use(); a++) begin
				if (pos[a] < 0 || pos[a] >= side_of(a)) return 1'b0;
				idx += pos[a] * scale;
				scale *= SIDE_MAX;
			end
			if (seen[idx]) return 1'b0;
			seen[idx] = 1'b1;
			sites++;
			return 1'b1;
		endfunction

		function longint torus_sites();
			longint p;
			p = 1;
			for (int a = 0; a < axes_in_use(); a++) p *= side_of(a);
			return p;
		endfunction

		// accepted input transaction: advance the walker and queue its result
		function void note_input(bit c, logic [AXIS_W-1:0] ax, bit sg, coord_t s0, coord_t s1,
				coord_t s2);
			int d;
			bit fresh;
			longint v, s;
			coord_t st [MAX_DIMS];
			res_t r;
			d = axes_in_use();
			fresh = 1'b0;
			st[0] = s0;
			st[1] = s1;
			st[2] = s2;
			if (c == CMD_PLACE) begin
				n_places++;
				for (int a = 0; a < MAX_DIMS; a++) begin
					v = 0;
					if (a < d) begin
						v = st[a];
						if (wrap_reg) begin
							if (v < 0) v = 0;
							if (v > side_of(a) - 1) v = side_of(a) - 1;
						end
					end
					pos[a] = v;
				end
				age_cnt = '0;
				far_sq = radius_sq();
				foreach (seen[i]) seen[i] = 1'b0;
				sites = 0;
				if (wrap_reg) fresh = visit_site();
			end else begin
				n_steps++;
				if (int'(ax) < d) begin
					v = pos[ax] + (sg ? -1 : 1);
					if (wrap_reg) begin
						s = side_of(ax);
						v = v % s;
						if (v < 0) v += s;
					end else begin
						if (v < -32768) v = -32768;
						if (v > 32767) v = 32767;
					end
					pos[ax] = v;
					if (age_cnt != '1) age_cnt++;
					if (radius_sq() > far_sq) far_sq = radius_sq();
					if (wrap_reg) fresh = visit_site();
				end
			end
			for (int a = 0; a < MAX_DIMS; a++) r.coord[a] = coord_t'(pos[a]);
			r.age = age_cnt;
			r.max_dist_sq = far_sq;
			r.alive = (radius_sq() >= 1);
			r.new_site = wrap_reg ? fresh : 1'b0;
			r.visited_count = wrap_reg ? COUNT_W'(sites) : '0;
			r.covered = wrap_reg ? (longint'(sites) >= torus_sites()) : 1'b0;
			pending = {pending, r};
		endfunction

		function void flag(string field, longint e, longint g);
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch, expected %0d got %0d", $time, field, e, g);
		endfunction

		// accepted output transaction: compare with the oldest expectation
		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("%0t: result with nothing expected", $time);
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (got.covered === 1'b1) n_covered++;
			for (int a = 0; a < MAX_DIMS; a++)
				if (got.coord[a] !== e.coord[a]) flag($sformatf("coord_%0d", a),
					e.coord[a], got.coord[a]);
			if (got.age !== e.age) flag("age", e.age, got.age);
			if (got.max_dist_sq !== e.max_dist_sq) flag("max_dist_sq", e.max_dist_sq,
				got.max_dist_sq);
			if (got.alive !== e.alive) flag("alive", e.alive, got.alive);
			if (got.new_site !== e.new_site) flag("new_site", e.new_site, got.new_site);
			if (got.visited_count !== e.visited_count) flag("visited_count",
				e.visited_count, got.visited_count);
			if (got.covered !== e.covered) flag("covered", e.covered, got.covered);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIDE_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic cmd;
	logic [AXIS_W-1:0] axis;
	logic sign;
	logic signed [COORD_BITS-1:0] start_0, start_1, start_2;
	logic out_valid, out_stall;
	logic signed [COORD_BITS-1:0] coord_0, coord_1, coord_2;
	logic [AGE_W-1:0] age;
	logic [DIST_W-1:0] max_dist_sq;
	logic alive, new_site, covered;
	logic [COUNT_W-1:0] visited_count;

	walk_scoreboard walk_sb;
	int cycles;
	int burst_left;

	lattice_walk_cover_tracker dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stall pattern: quiet, random, long blocks and sparse, in turn
	always @(posedge clk) begin
		case (cycles[10:9])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= 1'($urandom_range(0, 1));
			2'd2: out_stall <= (cycles[3:0] < 4'd9);
			default: out_stall <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// input monitor: every accepted transaction goes to the model
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			walk_sb.note_input(cmd, axis, sign, start_0, start_1, start_2);
	end

	// output monitor
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.coord[0] = coord_0;
			got.coord[1] = coord_1;
			got.coord[2] = coord_2;
			got.age = age;
			got.max_dist_sq = max_dist_sq;
			got.alive = alive;
			got.new_site = new_site;
			got.visited_count = visited_count;
			got.covered = covered;
			walk_sb.check_result(got);
		end
	end

	// one transaction; bursts of random length with random gaps between them
	task automatic send_item(bit c, logic [AXIS_W-1:0] ax, bit sg, coord_t s0, coord_t s1,
			coord_t s2);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		axis <= ax;
		sign <= sg;
		start_0 <= s0;
		start_1 <= s1;
		start_2 <= s2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drain all results, then let the map sweep finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (walk_sb.pending.size() != 0) @(posedge clk);
		repeat (SWEEP_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		walk_sb.set_reg(idx, val);
	endtask

	task automatic set_lattice(int d, int w, int s0, int s1, int s2);
		write_reg(REG_DIM_COUNT, SIDE_W'(d));
		write_reg(REG_WRAP_MODE, SIDE_W'(w));
		write_reg(REG_SIDE_0, SIDE_W'(s0));
		write_reg(REG_SIDE_1, SIDE_W'(s1));
		write_reg(REG_SIDE_2, SIDE_W'(s2));
		@(posedge clk);
	endtask

	// start coordinate: half the time near the lattice, otherwise extreme or fully random
	function automatic coord_t pick_start();
		case ($urandom_range(0, 5))
			0: return coord_t'(16'h8000);
			1: return coord_t'(16'h7FFF);
			2: return coord_t'($urandom());
			default: return coord_t'(int'($urandom_range(0, 22)) - 3);
		endcase
	endfunction

	// random walk: occasional placements, mostly steps
	task automatic walk_phase(int n, int place_pct, bit place_first);
		for (int i = 0; i < n; i++) begin
			if ((i == 0 && place_first) || $urandom_range(0, 99) < place_pct)
				send_item(CMD_PLACE, AXIS_W'($urandom()), 1'($urandom()), pick_start(),
					pick_start(), pick_start());
			else
				send_item(CMD_STEP, AXIS_W'($urandom_range(0, 3)), 1'($urandom()),
					coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
		end
		settle();
	endtask

	initial begin
		walk_sb = new();
		cycles <= 0;
		burst_left = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		cmd <= 1'b0;
		axis <= '0;
		sign <= 1'b0;
		start_0 <= '0;
		start_1 <= '0;
		start_2 <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings are a 16 x 16 torus
		send_item(CMD_STEP, 2'd0, 1'b1, '0, '0, '0);   // wrap below zero before any place
		send_item(CMD_PLACE, 2'd3, 1'b1, '0, '0, '0);  // place at the origin
		send_item(CMD_STEP, 2'd0, 1'b0, '0, '0, '0);
		send_item(CMD_STEP, 2'd1, 1'b0, '0, '0, '0);
		send_item(CMD_STEP, 2'd1, 1'b1, '0, '0, '0);   // revisit, no first visit
		send_item(CMD_STEP, 2'd2, 1'b0, '0, '0, '0);   // axis not in use
		send_item(CMD_STEP, 2'd3, 1'b1, '0, '0, '0);
		send_item(CMD_PLACE, 2'd0, 1'b0, coord_t'(16'h7FFF), coord_t'(16'h8000),
			coord_t'(16'h7FFF));                        // clamped into the torus
		send_item(CMD_STEP, 2'd0, 1'b0, '0, '0, '0);   // wraps to zero
		send_item(CMD_STEP, 2'd1, 1'b1, '0, '0, '0);   // wraps to the top
		settle();

		// free lattice in three axes: saturation at both coordinate limits
		set_lattice(3, 0, 16, 16, 16);
		send_item(CMD_PLACE, 2'd0, 1'b0, coord_t'(16'h7FFF), coord_t'(16'h8000),
			coord_t'(16'h8000));
		send_item(CMD_STEP, 2'd0, 1'b0, '0, '0, '0);
		send_item(CMD_STEP, 2'd1, 1'b1, '0, '0, '0);
		send_item(CMD_STEP, 2'd2, 1'b0, '0, '0, '0);
		send_item(CMD_STEP, 2'd3, 1'b0, '0, '0, '0);
		walk_phase(70, 4, 1'b0);

		// switch to a small torus without placing: site outside the torus
		set_lattice(2, 1, 4, 3, 16);
		walk_phase(40, 0, 1'b0);
		walk_phase(80, 3, 1'b1);

		// one axis of four sites, covered quickly
		set_lattice(1, 1, 4, 16, 16);
		walk_phase(90, 4, 1'b1);

		// shrink the sides after a long walk: positions left outside
		set_lattice(2, 1, 16, 16, 16);
		send_item(CMD_PLACE, 2'd0, 1'b0, 16'sd15, 16'sd15, '0);
		walk_phase(20, 0, 1'b0);
		set_lattice(3, 1, 5, 2, 3);
		walk_phase(80, 3, 1'b0);

		// 2 x 2 x 2 cube
		set_lattice(3, 1, 2, 2, 2);
		walk_phase(90, 4, 1'b1);

		// zero dimension count and zero side act as one: a single site
		set_lattice(0, 1, 0, 0, 0);
		walk_phase(40, 10, 1'b1);

		// sides above the maximum act as the maximum
		set_lattice(3, 1, 31, 17, 16);
		walk_phase(90, 3, 1'b1);

		// free lattice in two axes
		set_lattice(2, 0, 1, 1, 1);
		walk_phase(90, 4, 1'b1);

		// free to periodic without a place: negative coordinates wrap
		set_lattice(2, 1, 3, 5, 7);
		walk_phase(80, 3, 1'b0);

		$display("walked %0d places and %0d steps, %0d results checked, %0d with full cover",
			walk_sb.n_places, walk_sb.n_steps, walk_sb.n_checked, walk_sb.n_covered);
		if (walk_sb.errors == 0 && walk_sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never arrived", walk_sb.errors,
				walk_sb.pending.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
